@@ hdl/pmce_pkg.sv @@
// ---------------------------------------------------------------------------
// pmce_pkg
// Shared types and constants of the patch match cost engine.
// ---------------------------------------------------------------------------
package pmce_pkg;

  localparam int unsigned SPATIAL_CAP = 200;
  localparam logic [19:0] W_APPEAR    = 20'd670753;
  localparam logic [10:0] W_SPATIAL   = 11'd1049;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic CFG_NUM_ROWS = 1'b0;
  localparam logic CFG_NUM_COLS = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPATIAL,
    ST_SP_DRAIN,
    ST_APPEAR,
    ST_AP_DRAIN,
    ST_MUL,
    ST_SUM,
    ST_OUT
  } state_t;

  // controller -> datapath commands
  typedef struct packed {
    logic load_req;     // latch the accepted request
    logic clear_sums;   // zero accumulators and held colour
    logic issue_sp;     // issue a 3x3 read at the offset index
    logic issue_ap;     // issue a 5x5 read at the offset index
    logic [4:0] offset; // window position index
    logic mul;          // register the weighted products
    logic sum;          // add the products
    logic capture;      // copy the finished costs into the result register
  } cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic pipe_busy;    // reads still in flight
  } stat_t;

endpackage

@@ hdl/pmce_if.sv @@
// ---------------------------------------------------------------------------
// pmce_req_if / pmce_res_if
// Request and result channels with valid/ready handshakes.
// ---------------------------------------------------------------------------
interface pmce_req_if;
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [7:0]        row;
  logic [7:0]        col;
  logic [7:0]        red;
  logic [7:0]        green;
  logic [7:0]        blue;
  logic              is_hole;
  logic signed [9:0] map_row;
  logic signed [9:0] map_col;
  modport source (output valid, req_type, row, col, red, green, blue, is_hole,
                  map_row, map_col, input ready);
  modport sink (input valid, req_type, row, col, red, green, blue, is_hole,
                map_row, map_col, output ready);
endinterface

interface pmce_res_if;
  logic        valid;
  logic        ready;
  logic [22:0] appearance_sum;
  logic [10:0] spatial_sum;
  logic [41:0] weighted_cost;
  modport source (output valid, appearance_sum, spatial_sum, weighted_cost,
                  input ready);
  modport sink (input valid, appearance_sum, spatial_sum, weighted_cost,
                output ready);
endinterface

@@ hdl/pmce_ctrl.sv @@
// ---------------------------------------------------------------------------
// pmce_ctrl
// Sequencer: steps the 3x3 and 5x5 windows and the final weighting.
// ---------------------------------------------------------------------------
module pmce_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_fire,
  input  logic             req_query,
  input  logic             res_fire,
  input  pmce_pkg::stat_t  stat,
  output logic             busy,
  output logic             res_valid,
  output pmce_pkg::cmd_t   cmd
);

  pmce_pkg::state_t state, state_next;
  logic [4:0] idx, idx_next;
  logic res_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= pmce_pkg::ST_IDLE;
      idx      <= '0;
      res_full <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (cmd.capture) res_full <= 1'b1;
      else if (res_fire) res_full <= 1'b0;
    end
  end

  assign res_valid = res_full;

  always_comb begin
    state_next = state;
    idx_next   = idx;
    case (state)
      pmce_pkg::ST_IDLE: begin
        idx_next = '0;
        if (req_fire && req_query) state_next = pmce_pkg::ST_SPATIAL;
      end
      pmce_pkg::ST_SPATIAL: begin
        idx_next = idx + 5'd1;
        if (idx == 5'd8) begin
          idx_next   = '0;
          state_next = pmce_pkg::ST_SP_DRAIN;
        end
      end
      pmce_pkg::ST_SP_DRAIN: begin
        if (!stat.pipe_busy) state_next = pmce_pkg::ST_APPEAR;
      end
      pmce_pkg::ST_APPEAR: begin
        idx_next = idx + 5'd1;
        if (idx == 5'd24) begin
          idx_next   = '0;
          state_next = pmce_pkg::ST_AP_DRAIN;
        end
      end
      pmce_pkg::ST_AP_DRAIN: begin
        if (!stat.pipe_busy) state_next = pmce_pkg::ST_MUL;
      end
      pmce_pkg::ST_MUL: state_next = pmce_pkg::ST_SUM;
      pmce_pkg::ST_SUM: state_next = pmce_pkg::ST_OUT;
      pmce_pkg::ST_OUT: begin
        if (!res_full || res_fire) state_next = pmce_pkg::ST_IDLE;
      end
      default: state_next = pmce_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.offset     = idx;
    busy           = 1'b1;
    case (state)
      pmce_pkg::ST_IDLE: begin
        busy           = 1'b0;
        cmd.load_req   = req_fire;
        cmd.clear_sums = 1'b1;
      end
      pmce_pkg::ST_SPATIAL: cmd.issue_sp = 1'b1;
      pmce_pkg::ST_APPEAR:  cmd.issue_ap = 1'b1;
      pmce_pkg::ST_MUL:     cmd.mul = 1'b1;
      pmce_pkg::ST_SUM:     cmd.sum = 1'b1;
      pmce_pkg::ST_OUT:     cmd.capture = !res_full || res_fire;
      default: ;
    endcase
  end

endmodule

@@ hdl/pmce_datapath.sv @@
// ---------------------------------------------------------------------------
// pmce_datapath
// Stores, window address generation, accumulators and weighting.
// ---------------------------------------------------------------------------
module pmce_datapath #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  pmce_pkg::cmd_t   cmd,
  output pmce_pkg::stat_t  stat,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [8:0]       cfg_data,
  input  logic             ld_we,
  input  logic [7:0]       in_row,
  input  logic [7:0]       in_col,
  input  logic [23:0]      in_rgb,
  input  logic             in_hole,
  input  logic signed [9:0] in_mr,
  input  logic signed [9:0] in_mc,
  output logic [22:0]      appearance_sum,
  output logic [10:0]      spatial_sum,
  output logic [41:0]      weighted_cost
);

  localparam int RB    = $clog2(MAX_ROWS);
  localparam int CB    = $clog2(MAX_COLS);
  localparam int AB    = RB + CB;
  localparam int DEPTH = 2 ** AB;
  localparam int SW    = 14; // signed coordinate width

  // stores: pixel+hole in one, mapping in another
  logic [24:0] pix_mem [DEPTH];
  logic [19:0] map_mem [DEPTH];

  logic [9:0] num_rows, num_cols; // clamped effective size
  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= (MAX_ROWS < 256) ? 10'(MAX_ROWS) : 10'd256;
      num_cols <= (MAX_COLS < 256) ? 10'(MAX_COLS) : 10'd256;
    end else if (cfg_we) begin
      if (cfg_index == pmce_pkg::CFG_NUM_ROWS) begin
        num_rows <= (cfg_data == 9'd0) ? 10'd1 :
                    (int'(cfg_data) > MAX_ROWS) ? 10'(MAX_ROWS) : {1'b0, cfg_data};
      end else begin
        num_cols <= (cfg_data == 9'd0) ? 10'd1 :
                    (int'(cfg_data) > MAX_COLS) ? 10'(MAX_COLS) : {1'b0, cfg_data};
      end
    end
  end

  // latched request
  logic [7:0] ti, tj;
  logic signed [9:0] fr, fc;
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      ti <= in_row;
      tj <= in_col;
      fr <= in_mr;
      fc <= in_mc;
    end
  end

  // window offsets from index: row by compare, column by subtract
  logic [2:0] wrow, wcol;
  logic signed [3:0] dr, dc;
  always_comb begin
    if (cmd.issue_sp) begin
      wrow = (cmd.offset >= 5'd6) ? 3'd2 : (cmd.offset >= 5'd3) ? 3'd1 : 3'd0;
      wcol = 3'(cmd.offset - {2'b0, wrow} * 5'd3);
      dr   = signed'({1'b0, wrow}) - 4'sd1;
      dc   = signed'({1'b0, wcol}) - 4'sd1;
    end else begin
      wrow = (cmd.offset >= 5'd20) ? 3'd4 : (cmd.offset >= 5'd15) ? 3'd3 :
             (cmd.offset >= 5'd10) ? 3'd2 : (cmd.offset >= 5'd5) ? 3'd1 : 3'd0;
      wcol = 3'(cmd.offset - {2'b0, wrow} * 5'd5);
      dr   = signed'({1'b0, wrow}) - 4'sd2;
      dc   = signed'({1'b0, wcol}) - 4'sd2;
    end
  end

  logic signed [SW-1:0] qr, qc, vr, vc;
  logic q_in, v_in, issue;
  always_comb begin
    qr = SW'(signed'({1'b0, ti})) + SW'(dr);
    qc = SW'(signed'({1'b0, tj})) + SW'(dc);
    vr = SW'(fr) + SW'(dr);
    vc = SW'(fc) + SW'(dc);
    q_in = (qr >= 0) && (qr < SW'(signed'({1'b0, num_rows}))) &&
           (qc >= 0) && (qc < SW'(signed'({1'b0, num_cols})));
    v_in = (vr >= 0) && (vr < SW'(signed'({1'b0, num_rows}))) &&
           (vc >= 0) && (vc < SW'(signed'({1'b0, num_cols})));
    issue = cmd.issue_sp || cmd.issue_ap;
  end

  logic [AB-1:0] qa, va, wa;
  assign qa = {qr[RB-1:0], qc[CB-1:0]};
  assign va = {vr[RB-1:0], vc[CB-1:0]};
  assign wa = {RB'(in_row), CB'(in_col)};

  logic ld_ok;
  assign ld_ok = ld_we && (int'(in_row) < MAX_ROWS) && (int'(in_col) < MAX_COLS);

  // port A: load writes / target reads; port B: source reads
  logic [24:0] pa_q, pb_q;
  logic [19:0] ma_q;
  always_ff @(posedge clk) begin
    if (ld_ok) begin
      pix_mem[wa] <= {in_hole, in_rgb};
      map_mem[wa] <= {in_mr, in_mc};
    end
    pa_q <= pix_mem[qa];
    ma_q <= map_mem[qa];
  end
  always_ff @(posedge clk) begin
    pb_q <= pix_mem[va];
  end

  // one stage of tags alongside the read
  logic s1_v, s1_sp, s1_vin;
  logic signed [SW-1:0] s1_er, s1_ec;
  logic s2_v, s2_sp;
  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else     s1_v <= issue && q_in;
    s1_sp  <= cmd.issue_sp;
    s1_vin <= v_in;
    s1_er  <= vr;
    s1_ec  <= vc;
  end
  assign stat.pipe_busy = s1_v || s2_v;

  // stage 2: differences and squares, registered
  logic [7:0] sp_term;
  logic [17:0] ap_term;
  logic [23:0] src_rgb, hold_rgb;
  logic signed [SW-1:0] er, ec;
  logic [2*SW-1:0] n2;
  logic signed [8:0] d0, d1, d2;
  always_comb begin
    er = SW'(signed'(ma_q[19:10])) - s1_er;
    ec = SW'(signed'(ma_q[9:0])) - s1_ec;
    n2 = (2*SW)'(er) * (2*SW)'(er) + (2*SW)'(ec) * (2*SW)'(ec);
    src_rgb = (s1_vin && !pb_q[24]) ? pb_q[23:0] : hold_rgb;
    d0 = signed'({1'b0, pa_q[23:16]}) - signed'({1'b0, src_rgb[23:16]});
    d1 = signed'({1'b0, pa_q[15:8]})  - signed'({1'b0, src_rgb[15:8]});
    d2 = signed'({1'b0, pa_q[7:0]})   - signed'({1'b0, src_rgb[7:0]});
  end
  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else     s2_v <= s1_v;
    s2_sp   <= s1_sp;
    sp_term <= (n2 < (2*SW)'(pmce_pkg::SPATIAL_CAP)) ? n2[7:0] : 8'(pmce_pkg::SPATIAL_CAP);
    ap_term <= 18'(d0) * 18'(d0) + 18'(d1) * 18'(d1) + 18'(d2) * 18'(d2);
    if (cmd.clear_sums) hold_rgb <= '0;
    else if (s1_v && !s1_sp) hold_rgb <= src_rgb;
  end

  logic [22:0] ap_acc;
  logic [10:0] sp_acc;
  logic [41:0] pa_prod, wsum;
  logic [21:0] ps_prod;
  always_ff @(posedge clk) begin
    if (cmd.clear_sums) begin
      ap_acc <= '0;
      sp_acc <= '0;
    end else if (s2_v) begin
      if (s2_sp) sp_acc <= sp_acc + 11'(sp_term);
      else       ap_acc <= ap_acc + 23'(ap_term);
    end
    if (cmd.mul) begin
      pa_prod <= 42'(ap_acc) * 42'(pmce_pkg::W_APPEAR);
      ps_prod <= 22'(sp_acc) * 22'(pmce_pkg::W_SPATIAL);
    end
    if (cmd.sum) wsum <= pa_prod + 42'(ps_prod);
    if (cmd.capture) begin
      appearance_sum <= ap_acc;
      spatial_sum    <= sp_acc;
      weighted_cost  <= wsum;
    end
  end

endmodule

@@ hdl/patch_match_cost_engine.sv @@
// ---------------------------------------------------------------------------
// patch_match_cost_engine
// Inpainting cost engine: stores image, hole map and mappings; answers queries
// with appearance, spatial and weighted cost.
// ---------------------------------------------------------------------------
//  channel  dir  handshake     carries
//  req      in   valid/ready   load or query request
//  res      out  valid/ready   appearance_sum, spatial_sum, weighted_cost
//  cfg      in   cfg_we        num_rows (index 0), num_cols (index 1)
//
// A load is written at its accepting edge. A query holds the engine from its
// accepting edge through the 3x3 mapping reads, a drain, the 5x5 pixel reads
// over the two memory ports, another drain, multiply, add and capture; the
// result is presented the cycle after capture. The single target read port
// makes both windows step one position at a time.
// A result waiting on res.ready stalls only the next query at its capture step.
// Reset (rst, synchronous) restores the size registers; stores need none.
// ---------------------------------------------------------------------------
module patch_match_cost_engine #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 256
) (
  input  logic          clk,
  input  logic          rst,
  pmce_req_if.sink      req,
  pmce_res_if.source    res,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [8:0]    cfg_data
);

  pmce_pkg::cmd_t  cmd;
  pmce_pkg::stat_t stat;
  logic busy, req_fire;

  // accept requests only while idle
  assign req.ready = !busy;
  assign req_fire  = req.valid && req.ready;

  pmce_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_fire  (req_fire),
    .req_query (req.req_type == pmce_pkg::REQ_QUERY),
    .res_fire  (res.valid && res.ready),
    .stat      (stat),
    .busy      (busy),
    .res_valid (res.valid),
    .cmd       (cmd)
  );

  pmce_datapath #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .ld_we          (req_fire && req.req_type == pmce_pkg::REQ_LOAD),
    .in_row         (req.row),
    .in_col         (req.col),
    .in_rgb         ({req.red, req.green, req.blue}),
    .in_hole        (req.is_hole),
    .in_mr          (req.map_row),
    .in_mc          (req.map_col),
    .appearance_sum (res.appearance_sum),
    .spatial_sum    (res.spatial_sum),
    .weighted_cost  (res.weighted_cost)
  );

endmodule
